>>> rtl/t3n_pkg.sv
package t3n_pkg;

  // fixed field widths
  localparam int POS_W    = 18;
  localparam int DIR_W    = 3;
  localparam int ADDR_W   = 21;
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_DIR  = 6;

  // quotient bits resolved per divider stage
  localparam int DIV_BPS  = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_I = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_J = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_K = 2'd2;

  // neighbor direction codes, in emission order
  typedef enum logic [DIR_W-1:0] {
    DIR_I_DN = 3'd0,
    DIR_I_UP = 3'd1,
    DIR_J_DN = 3'd2,
    DIR_J_UP = 3'd3,
    DIR_K_DN = 3'd4,
    DIR_K_UP = 3'd5
  } dir_t;

  // grid geometry as seen by the result serializer (position arithmetic is mod 2^POS_W)
  typedef struct packed {
    logic [POS_W-1:0]  ni;
    logic [POS_W-1:0]  plane;
    logic [POS_W-1:0]  cells;
    logic [ADDR_W-1:0] cells_addr;
  } geom_t;

  // one decoded position handed to the serializer
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             ok;
    logic [2:0]       at_lo;   // coordinate is 0, per axis k j i
    logic [2:0]       at_hi;   // coordinate is extent-1, per axis k j i
  } item_t;

endpackage

>>> rtl/t3n_div.sv
module t3n_div #(
  parameter int DW = 7,
  parameter int TW = 18
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [t3n_pkg::POS_W-1:0] dividend,
  input  logic [DW-1:0]             divisor,
  input  logic [TW-1:0]             in_tag,
  output logic                      out_valid,
  output logic [t3n_pkg::POS_W-1:0] quotient,
  output logic [DW-1:0]             remainder,
  output logic [TW-1:0]             out_tag
);

  localparam int QW   = t3n_pkg::POS_W;
  localparam int NSTG = t3n_pkg::POS_W / t3n_pkg::DIV_BPS;

  logic [NSTG-1:0] vld;
  logic [DW-1:0]   rem [NSTG];
  logic [QW-1:0]   dq  [NSTG];
  logic [TW-1:0]   tag [NSTG];

  // a few restoring steps: dividend bits shift out the top, quotient bits in the bottom
  function automatic logic [DW+QW-1:0] div_step(input logic [DW-1:0] r_in,
                                                input logic [QW-1:0] w_in,
                                                input logic [DW-1:0] d);
    logic [DW-1:0] r;
    logic [QW-1:0] w;
    logic [DW:0]   t;
    r = r_in;
    w = w_in;
    for (int b = 0; b < t3n_pkg::DIV_BPS; b++) begin
      t = {r, w[QW-1]};
      w = {w[QW-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t    = t - {1'b0, d};
        w[0] = 1'b1;
      end
      r = t[DW-1:0];
    end
    return {r, w};
  endfunction

  // divider stages, all advancing together on en
  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    logic [DW-1:0] r_in;
    logic [QW-1:0] w_in;
    logic [TW-1:0] t_in;
    logic          v_in;

    if (s == 0) begin : g_first
      assign r_in = '0;
      assign w_in = dividend;
      assign t_in = in_tag;
      assign v_in = in_valid;
    end else begin : g_next
      assign r_in = rem[s-1];
      assign w_in = dq[s-1];
      assign t_in = tag[s-1];
      assign v_in = vld[s-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        {rem[s], dq[s]} <= div_step(r_in, w_in, divisor);
        tag[s]          <= t_in;
      end
    end
  end

  assign out_valid = vld[NSTG-1];
  assign quotient  = dq[NSTG-1];
  assign remainder = rem[NSTG-1];
  assign out_tag   = tag[NSTG-1];

endmodule

>>> rtl/t3n_emit.sv
module t3n_emit (
  input  logic                       clk,
  input  logic                       rst,
  input  t3n_pkg::geom_t             geom,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  t3n_pkg::item_t             in_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output t3n_pkg::dir_t              out_dir,
  output logic [t3n_pkg::POS_W-1:0]  out_nb,
  output logic [t3n_pkg::ADDR_W-1:0] out_addr,
  output logic                       out_ok,
  output logic                       out_last
);

  localparam int PW = t3n_pkg::POS_W;
  localparam int AW = t3n_pkg::ADDR_W;

  t3n_pkg::item_t item;
  logic           item_valid;
  t3n_pkg::dir_t  cnt;
  logic [AW-1:0]  addr_acc;

  logic          produce;
  logic          at_last;
  logic          take;
  logic [PW-1:0] stride;
  logic [PW-1:0] span;
  logic          wrap;
  logic          down;
  logic [PW-1:0] nb_next;

  assign produce  = item_valid && (!out_valid || out_ready);
  assign at_last  = (cnt == t3n_pkg::DIR_K_UP);
  assign in_ready = !item_valid || (produce && at_last);
  assign take     = in_valid && in_ready;

  // axis stride and span for the current direction
  always_comb begin
    down = 1'b0;
    unique case (cnt)
      t3n_pkg::DIR_I_DN: begin
        stride = PW'(1);          span = geom.ni;    wrap = item.at_lo[0]; down = 1'b1;
      end
      t3n_pkg::DIR_I_UP: begin
        stride = PW'(1);          span = geom.ni;    wrap = item.at_hi[0];
      end
      t3n_pkg::DIR_J_DN: begin
        stride = geom.ni;         span = geom.plane; wrap = item.at_lo[1]; down = 1'b1;
      end
      t3n_pkg::DIR_J_UP: begin
        stride = geom.ni;         span = geom.plane; wrap = item.at_hi[1];
      end
      t3n_pkg::DIR_K_DN: begin
        stride = geom.plane;      span = geom.cells; wrap = item.at_lo[2]; down = 1'b1;
      end
      t3n_pkg::DIR_K_UP: begin
        stride = geom.plane;      span = geom.cells; wrap = item.at_hi[2];
      end
      default: begin
        stride = '0;              span = '0;         wrap = 1'b0;
      end
    endcase
  end

  // wrapped neighbor: step one stride, or jump across the span at the edge; zero for an out of range item
  always_comb begin
    priority if (!item.ok) begin
      nb_next = '0;
    end else if (down && wrap) begin
      nb_next = item.pos + span - stride;
    end else if (down) begin
      nb_next = item.pos - stride;
    end else if (wrap) begin
      nb_next = item.pos - span + stride;
    end else begin
      nb_next = item.pos + stride;
    end
  end

  // held item and direction counter
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      cnt        <= t3n_pkg::DIR_I_DN;
    end else if (take) begin
      item_valid <= 1'b1;
      cnt        <= t3n_pkg::DIR_I_DN;
    end else if (produce) begin
      if (at_last) begin
        item_valid <= 1'b0;
        cnt        <= t3n_pkg::DIR_I_DN;
      end else begin
        cnt <= t3n_pkg::dir_t'(cnt + t3n_pkg::DIR_W'(1));
      end
    end
  end

  // item payload and running table address
  always_ff @(posedge clk) begin
    if (take) begin
      item     <= in_item;
      addr_acc <= AW'(in_item.pos);
    end else if (produce) begin
      addr_acc <= addr_acc + geom.cells_addr;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (produce) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      out_dir  <= cnt;
      out_nb   <= nb_next;
      out_addr <= item.ok ? addr_acc : '0;
      out_ok   <= item.ok;
      out_last <= at_last;
    end
  end

  // last word of a run is always the +k neighbor
  a_last_dir: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_dir == t3n_pkg::DIR_K_UP)
    else $error("last word not on +k direction");

  // out of range positions carry zero payload
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ok |-> out_nb == '0 && out_addr == '0)
    else $error("out of range word with nonzero payload");

  // a held item is replaced only while its sixth word goes out
  a_replace: assert property (@(posedge clk) disable iff (rst)
    take && item_valid |-> produce && at_last)
    else $error("held item replaced before its run finished");

  // a run starts with the -i direction
  a_run_start: assert property (@(posedge clk) disable iff (rst)
    take |=> cnt == t3n_pkg::DIR_I_DN && item_valid)
    else $error("run did not restart at -i");

endmodule

>>> rtl/torus3d_neighbor_table.sv
// Face neighbor generator for a periodic 3D cell grid.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data writes size_i (0), size_j (1)
// and size_k (2); cfg_ready is always high. A size of 0 acts as 1, above MAX_DIM as MAX_DIM.
// Write the sizes only while no position is in flight.
// Input: one linear position per s_tdata word. Output: six words per position in the
// order -i, +i, -j, +j, -k, +k, each with the neighbor position and the table address
// direction*cells+position; m_tuser flags a position inside the grid, m_tlast marks the
// sixth word.
// Flow: coordinates come from two pipelined dividers of six stages each; a range-check
// register and the serializer's item register follow, then the first word of a position
// enters the output register and the other five follow one per cycle while m_tready is
// high. In free flow a new position is taken as the previous one's sixth word goes out.
// Reset: sizes return to 1 and all in-flight words are dropped.
// Stall: when m_tready is low the output word holds, and the pipeline behind it stops
// once the serializer is full; s_tready then goes low and nothing is lost or repeated.
module torus3d_neighbor_table #(
  parameter int MAX_DIM = 64
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  // position words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [17:0] position, [23:18] zero
  // neighbor words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [2:0] direction, [20:3] neighbor_position,
                                 // [41:21] table_address, [47:42] zero
  output logic        m_tuser,   // [0] in_range
  output logic        m_tlast
);

  localparam int DW   = $clog2(MAX_DIM + 1);
  localparam int PLW  = 2 * DW;
  localparam int CW   = 3 * DW;
  localparam int PW   = t3n_pkg::POS_W;
  localparam int AW   = t3n_pkg::ADDR_W;
  localparam int CMPW = (CW > PW) ? CW : PW;

  logic [t3n_pkg::CFG_W-1:0] size_i;
  logic [t3n_pkg::CFG_W-1:0] size_j;
  logic [t3n_pkg::CFG_W-1:0] size_k;

  logic [DW-1:0]  ni;
  logic [DW-1:0]  nj;
  logic [DW-1:0]  nk;
  logic [PLW-1:0] plane;
  logic [CW-1:0]  cells;

  logic           advance;
  logic           d1_valid;
  logic [PW-1:0]  d1_quot;
  logic [DW-1:0]  d1_rem;
  logic [PW-1:0]  d1_tag;
  logic           d2_valid;
  logic [PW-1:0]  d2_quot;
  logic [DW-1:0]  d2_rem;
  logic [PW+DW-1:0] d2_tag;

  logic           f_valid;
  t3n_pkg::item_t f_item;
  t3n_pkg::item_t f_next;
  logic           emit_ready;
  t3n_pkg::geom_t geom;

  t3n_pkg::dir_t  out_dir;
  logic [PW-1:0]  out_nb;
  logic [AW-1:0]  out_addr;

  // clamp a size register to 1..MAX_DIM
  function automatic logic [DW-1:0] extent(input logic [t3n_pkg::CFG_W-1:0] r);
    logic [DW-1:0] e;
    if (r == '0) begin
      e = DW'(1);
    end else if (int'(r) > MAX_DIM) begin
      e = DW'(MAX_DIM);
    end else begin
      e = DW'(r);
    end
    return e;
  endfunction

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_i <= t3n_pkg::CFG_W'(1);
      size_j <= t3n_pkg::CFG_W'(1);
      size_k <= t3n_pkg::CFG_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        t3n_pkg::REG_SIZE_I: size_i <= cfg_data;
        t3n_pkg::REG_SIZE_J: size_j <= cfg_data;
        t3n_pkg::REG_SIZE_K: size_k <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ni = extent(size_i);
  assign nj = extent(size_j);
  assign nk = extent(size_k);

  // plane and cell counts, plane registered from the sizes and cells from plane, long before a position needs them
  always_ff @(posedge clk) begin
    plane <= PLW'(ni) * PLW'(nj);
    cells <= CW'(plane) * CW'(nk);
  end

  assign geom.ni         = PW'(ni);
  assign geom.plane      = PW'(plane);
  assign geom.cells      = PW'(cells);
  assign geom.cells_addr = AW'(cells);

  // whole pipeline moves together whenever the last stage can hand off
  assign advance  = !f_valid || emit_ready;
  assign s_tready = advance;

  // position / ni gives ci and the row index
  t3n_div #(.DW(DW), .TW(PW)) u_div_i (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (s_tvalid),
    .dividend  (s_tdata[PW-1:0]),
    .divisor   (ni),
    .in_tag    (s_tdata[PW-1:0]),
    .out_valid (d1_valid),
    .quotient  (d1_quot),
    .remainder (d1_rem),
    .out_tag   (d1_tag)
  );

  // row index / nj gives cj and ck
  t3n_div #(.DW(DW), .TW(PW + DW)) u_div_j (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (d1_valid),
    .dividend  (d1_quot),
    .divisor   (nj),
    .in_tag    ({d1_tag, d1_rem}),
    .out_valid (d2_valid),
    .quotient  (d2_quot),
    .remainder (d2_rem),
    .out_tag   (d2_tag)
  );

  // range check and edge flags per axis
  always_comb begin
    f_next.pos      = d2_tag[PW+DW-1:DW];
    f_next.ok       = CMPW'(d2_tag[PW+DW-1:DW]) < CMPW'(cells);
    f_next.at_lo[0] = (d2_tag[DW-1:0] == '0);
    f_next.at_hi[0] = (d2_tag[DW-1:0] == ni - DW'(1));
    f_next.at_lo[1] = (d2_rem == '0);
    f_next.at_hi[1] = (d2_rem == nj - DW'(1));
    f_next.at_lo[2] = (d2_quot == '0);
    f_next.at_hi[2] = (d2_quot == PW'(nk) - PW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (advance) begin
      f_valid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      f_item <= f_next;
    end
  end

  // six-word serializer with output register
  t3n_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .geom      (geom),
    .in_valid  (f_valid),
    .in_ready  (emit_ready),
    .in_item   (f_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_dir   (out_dir),
    .out_nb    (out_nb),
    .out_addr  (out_addr),
    .out_ok    (m_tuser),
    .out_last  (m_tlast)
  );

  assign m_tdata = {6'd0, out_addr, out_nb, out_dir};

endmodule
